// ===== hdl/fpmd_pkg.sv =====
package fpmd_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int SAT_SHIFT = 14;
    // quotient below 2^31 once saturation is ruled out
    localparam int QUOT_W    = WORD_W - 1;
    localparam int DIV_STEPS = QUOT_W;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_STEPS + 1;

    localparam logic KIND_MUL = 1'b0;
    localparam logic KIND_DIV = 1'b1;

    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    // one pipeline slot; for a multiply, rem holds the low partial product
    // and dvsr the high partial product until they are summed
    typedef struct packed {
        logic              kind;
        logic              neg;
        logic              sat;
        logic [WORD_W-1:0] dvsr;
        logic [WORD_W-1:0] rem;
        logic [QUOT_W-1:0] dq;
    } stage_t;

endpackage

// ===== hdl/fpmd_front.sv =====
module fpmd_front
    import fpmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     kind,
    input  logic signed [WORD_W-1:0] operand_a,
    input  logic signed [WORD_W-1:0] operand_b,
    output logic                     out_valid,
    output stage_t                   out_stage
);

    logic              s1_valid_reg;
    logic              s1_kind_reg;
    logic              s1_neg_reg;
    logic [WORD_W-1:0] s1_ma_reg;
    logic [WORD_W-1:0] s1_mb_reg;
    logic [WORD_W-1:0] s1_ma_next;
    logic [WORD_W-1:0] s1_mb_next;

    logic              s2_valid_reg;
    stage_t            s2_reg;
    stage_t            s2_next;
    logic [47:0]       prod_lo;
    logic [47:0]       prod_hi;

    logic              s3_valid_reg;
    stage_t            s3_reg;
    stage_t            s3_next;

    // stage 1: magnitudes
    always_comb
    begin
        s1_ma_next = operand_a[WORD_W-1] ? WORD_W'(32'd0 - $unsigned(operand_a))
                                         : $unsigned(operand_a);
        s1_mb_next = operand_b[WORD_W-1] ? WORD_W'(32'd0 - $unsigned(operand_b))
                                         : $unsigned(operand_b);
    end

    // stage 2: partial products, saturation test, division setup
    always_comb
    begin
        prod_lo = 48'(s1_ma_reg) * 48'(s1_mb_reg[FRAC_W-1:0]);
        prod_hi = 48'(s1_ma_reg) * 48'(s1_mb_reg[WORD_W-1:FRAC_W]);
        s2_next.kind = s1_kind_reg;
        s2_next.neg  = s1_neg_reg;
        s2_next.sat  = (s1_ma_reg >> SAT_SHIFT) >= s1_mb_reg;
        if (s1_kind_reg == KIND_DIV)
        begin
            s2_next.dvsr = s1_mb_reg;
            s2_next.rem  = WORD_W'(s1_ma_reg[WORD_W-1:QUOT_W-FRAC_W]);
            s2_next.dq   = {s1_ma_reg[QUOT_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        end
        else
        begin
            s2_next.dvsr = prod_hi[WORD_W-1:0];
            s2_next.rem  = prod_lo[47:FRAC_W];
            s2_next.dq   = '0;
        end
    end

    // stage 3: product sum, divides pass through
    always_comb
    begin
        s3_next = s2_reg;
        if (s2_reg.kind == KIND_MUL)
        begin
            s3_next.rem = s2_reg.rem + s2_reg.dvsr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= kind;
        s1_neg_reg  <= operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
        s1_ma_reg   <= s1_ma_next;
        s1_mb_reg   <= s1_mb_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_stage = s3_reg;

endmodule

// ===== hdl/fpmd_div_step.sv =====
module fpmd_div_step
    import fpmd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    logic              valid_reg;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              fits;

    // one restoring step: bring down the next dividend bit, try a subtract
    always_comb
    begin
        trial = {in_stage.rem, in_stage.dq[QUOT_W-1]};
        diff  = trial - {1'b0, in_stage.dvsr};
        fits  = trial >= {1'b0, in_stage.dvsr};
        stage_next = in_stage;
        if (in_stage.kind == KIND_DIV)
        begin
            stage_next.rem = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            stage_next.dq  = {in_stage.dq[QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== hdl/fpmd_back.sv =====
module fpmd_back
    import fpmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  stage_t                   in_stage,
    output logic                     done,
    output logic signed [WORD_W-1:0] result_value
);

    logic              done_reg;
    logic [WORD_W-1:0] result_value_reg;
    logic [WORD_W-1:0] result_value_next;
    logic [WORD_W-1:0] mag;

    always_comb
    begin
        mag = (in_stage.kind == KIND_MUL) ? in_stage.rem : {1'b0, in_stage.dq};
        if (in_stage.kind == KIND_DIV && in_stage.sat)
        begin
            result_value_next = in_stage.neg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            result_value_next = in_stage.neg ? WORD_W'(32'd0 - mag) : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
    end

    assign done         = done_reg;
    assign result_value = $signed(result_value_reg);

endmodule

// ===== hdl/fixed_point_mul_div_16_16.sv =====
// signed 16.16 fixed-point multiply / divide unit
//
// input: drive kind (0 multiply, 1 divide), operand_a and operand_b and raise
// start; a transaction is taken at every rising edge with start high and busy
// low. busy stays low, so a new transaction can be issued every cycle.
// output: done is high for exactly one cycle with result_value valid in that
// cycle. results come back in issue order. throughput is one transaction per
// cycle; the pipeline is a 31-stage restoring divider array (one quotient
// bit per stage) behind three front stages (magnitudes, partial products,
// product sum) and one output register.
// multiply gives the low 32 bits of |a|*|b|>>16, divide gives (|a|<<16)/|b|,
// both sign-corrected toward zero; divide saturates when (|a|>>14) >= |b|,
// which includes division by zero.
// reset clears only the valid bits; transactions in flight are dropped.
// the receiver cannot stall: each result must be taken in its done cycle.
module fixed_point_mul_div_16_16
    import fpmd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic signed [WORD_W-1:0] operand_a,
    input  logic signed [WORD_W-1:0] operand_b,
    output logic                     done,
    output logic signed [WORD_W-1:0] result_value
);

    logic   step_valid [DIV_STEPS+1];
    stage_t step_stage [DIV_STEPS+1];

    assign busy = 1'b0;

    fpmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (step_valid[0]),
        .out_stage (step_stage[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        fpmd_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[i]),
            .in_stage  (step_stage[i]),
            .out_valid (step_valid[i+1]),
            .out_stage (step_stage[i+1])
        );
    end

    fpmd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (step_valid[DIV_STEPS]),
        .in_stage     (step_stage[DIV_STEPS]),
        .done         (done),
        .result_value (result_value)
    );

endmodule

// ===== hdl/fpmd_checker.sv =====
module fpmd_checker
    import fpmd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     kind,
    input logic signed [WORD_W-1:0] operand_a,
    input logic signed [WORD_W-1:0] operand_b,
    input logic                     done,
    input logic signed [WORD_W-1:0] result_value
);

    // the pipeline always takes a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("transaction produced no result");

    // product of zero is zero
    a_mul_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_MUL && operand_b == '0)
            |-> ##PIPE_LATENCY (result_value == '0))
        else $error("multiply by zero not zero");

    // division by zero saturates by the dividend sign seen at issue
    a_div_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_DIV && operand_b == '0)
            |-> ##PIPE_LATENCY (result_value ==
                ($past(operand_a[WORD_W-1], PIPE_LATENCY) ?
                $signed(SAT_NEG) : $signed(SAT_POS))))
        else $error("divide by zero not saturated");

endmodule

bind fixed_point_mul_div_16_16 fpmd_checker u_fpmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .result_value (result_value)
);
